FILE: design/ipv4_receive_header_classifier_macros.svh
// Assertion macros for the IPv4 receive header classifier.
// Used by the port checker; depends on nothing else.
`ifndef IPV4_RECEIVE_HEADER_CLASSIFIER_MACROS_SVH
`define IPV4_RECEIVE_HEADER_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled in reset
`define IPV4RHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IPV4RHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ipv4rhc_pkg.sv
// Shared types, constants and functions for the IPv4 receive header classifier.
// No dependencies.
package ipv4rhc_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [4:0]  WORD_IDX_MAX   = 5'd31;
   localparam logic [4:0]  HDR_WORDS_MIN  = 5'd10;
   localparam logic [15:0] HDR_BYTES_MIN  = 16'd20;
   localparam logic [3:0]  IP_VERSION     = 4'd4;
   localparam logic [3:0]  IHL_USES_TTL   = 4'd3;

   // header word positions
   localparam logic [4:0] WORD_VER_IHL   = 5'd0;
   localparam logic [4:0] WORD_TOTAL_LEN = 5'd1;
   localparam logic [4:0] WORD_TTL_PROTO = 5'd4;
   localparam logic [4:0] WORD_CHECKSUM  = 5'd5;
   localparam logic [4:0] WORD_SRC_HI    = 5'd6;
   localparam logic [4:0] WORD_SRC_LO    = 5'd7;
   localparam logic [4:0] WORD_DST_HI    = 5'd8;
   localparam logic [4:0] WORD_DST_LO    = 5'd9;

   localparam logic [2:0] VERDICT_LOCAL    = 3'd0;
   localparam logic [2:0] VERDICT_FORWARD  = 3'd1;
   localparam logic [2:0] VERDICT_SHORT    = 3'd2;
   localparam logic [2:0] VERDICT_VERSION  = 3'd3;
   localparam logic [2:0] VERDICT_CHECKSUM = 3'd4;
   localparam logic [2:0] VERDICT_LENGTH   = 3'd5;
   localparam logic [2:0] VERDICT_TTL      = 3'd6;

   localparam logic [2:0] CSR_IF0_ADDR    = 3'd0;
   localparam logic [2:0] CSR_IF0_PREFIX  = 3'd1;
   localparam logic [2:0] CSR_IF0_ADAPTER = 3'd2;
   localparam logic [2:0] CSR_IF1_ADDR    = 3'd3;
   localparam logic [2:0] CSR_IF1_PREFIX  = 3'd4;
   localparam logic [2:0] CSR_IF1_ADAPTER = 3'd5;
   localparam logic [2:0] CSR_IF_ENABLE   = 3'd6;

   localparam logic [5:0] PREFIX_RESET = 6'd24;
   localparam int         CSR_ADDR_W   = 5;

   typedef struct packed {
      logic [15:0] header_word;
      logic        last_word;
      logic [15:0] frame_length;
      logic [3:0]  adapter_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        iface_index;
      logic [7:0]  protocol;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] payload_length;
      logic [7:0]  ttl_out;
      logic [15:0] checksum_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] if0_addr;
      logic [5:0]  if0_prefix;
      logic [3:0]  if0_adapter;
      logic [31:0] if1_addr;
      logic [5:0]  if1_prefix;
      logic [3:0]  if1_adapter;
      logic [1:0]  if_enable;
   } cfg_type;

   // one finished header, handed from front to back
   typedef struct packed {
      logic [4:0]  word_count;
      logic [16:0] sum_acc;
      logic [7:0]  version_ihl;
      logic [15:0] total_len;
      logic [15:0] ttl_proto;
      logic [15:0] stored_csum;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] frame_length;
      logic [3:0]  adapter_id;
   } pkt_type;

   function automatic logic [16:0] add_carry(input logic [16:0] a, input logic [15:0] b);
      logic [17:0] s0;
      logic [16:0] s1;
      logic [16:0] s2;
      begin
         s0 = {1'b0, a} + {2'b00, b};
         s1 = {1'b0, s0[15:0]} + {15'd0, s0[17:16]};
         s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
         return s2;
      end
   endfunction

   function automatic logic [31:0] prefix_mask(input logic [5:0] prefix);
      logic [5:0] p;
      begin
         p = (prefix > 6'd32) ? 6'd32 : prefix;
         if (p == 6'd0) begin
            return 32'd0;
         end
         return 32'hFFFF_FFFF << (6'd32 - p);
      end
   endfunction

   function automatic logic iface_match(input logic [31:0] addr, input logic [5:0] prefix,
                                        input logic [3:0] adapter, input logic enabled,
                                        input logic [3:0] adp, input logic [31:0] dst);
      logic [31:0] m;
      begin
         m = prefix_mask(prefix);
         if (!enabled || adapter != adp) begin
            return 1'b0;
         end
         return (dst == addr) || (((dst & m) == (addr & m)) && ((dst | m) == 32'hFFFF_FFFF));
      end
   endfunction

endpackage

FILE: design/ipv4_receive_header_classifier.sv
// IPv4 receive header classifier: one header word per cycle while req_full is low.
// One result per last word, via the header queue, back-end s1 and output registers.
// The back end retires one header per cycle unless a result waits unpopped.
// req_full rises only when the header queue between front and back end is full.
// Reset is synchronous: clears packet state and queues, interface registers to defaults.
// Depends on ipv4rhc_pkg, ipv4rhc_fifo, ipv4rhc_front, ipv4rhc_back.
module ipv4_receive_header_classifier #(
   parameter int QueueDepth = ipv4rhc_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  ipv4rhc_pkg::req_type                  req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output ipv4rhc_pkg::rsp_type                  rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ipv4rhc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   ipv4rhc_pkg::cfg_type cfg_ff, cfg_in;
   ipv4rhc_pkg::pkt_type push_pkt, head_pkt;
   logic       accept, pkt_push, pkt_pop, q_full, q_empty, rsp_valid;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            ipv4rhc_pkg::CSR_IF0_ADDR:    cfg_in.if0_addr    = csr_pwdata;
            ipv4rhc_pkg::CSR_IF0_PREFIX:  cfg_in.if0_prefix  = csr_pwdata[5:0];
            ipv4rhc_pkg::CSR_IF0_ADAPTER: cfg_in.if0_adapter = csr_pwdata[3:0];
            ipv4rhc_pkg::CSR_IF1_ADDR:    cfg_in.if1_addr    = csr_pwdata;
            ipv4rhc_pkg::CSR_IF1_PREFIX:  cfg_in.if1_prefix  = csr_pwdata[5:0];
            ipv4rhc_pkg::CSR_IF1_ADAPTER: cfg_in.if1_adapter = csr_pwdata[3:0];
            ipv4rhc_pkg::CSR_IF_ENABLE:   cfg_in.if_enable   = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ipv4rhc_pkg::CSR_IF0_ADDR:    csr_prdata = cfg_ff.if0_addr;
         ipv4rhc_pkg::CSR_IF0_PREFIX:  csr_prdata = {26'd0, cfg_ff.if0_prefix};
         ipv4rhc_pkg::CSR_IF0_ADAPTER: csr_prdata = {28'd0, cfg_ff.if0_adapter};
         ipv4rhc_pkg::CSR_IF1_ADDR:    csr_prdata = cfg_ff.if1_addr;
         ipv4rhc_pkg::CSR_IF1_PREFIX:  csr_prdata = {26'd0, cfg_ff.if1_prefix};
         ipv4rhc_pkg::CSR_IF1_ADAPTER: csr_prdata = {28'd0, cfg_ff.if1_adapter};
         ipv4rhc_pkg::CSR_IF_ENABLE:   csr_prdata = {30'd0, cfg_ff.if_enable};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.if0_addr    <= 32'd0;
         cfg_ff.if0_prefix  <= ipv4rhc_pkg::PREFIX_RESET;
         cfg_ff.if0_adapter <= 4'd0;
         cfg_ff.if1_addr    <= 32'd0;
         cfg_ff.if1_prefix  <= ipv4rhc_pkg::PREFIX_RESET;
         cfg_ff.if1_adapter <= 4'd0;
         cfg_ff.if_enable   <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign rsp_empty = !rsp_valid;

   ipv4rhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .pkt_push (pkt_push),
      .pkt      (push_pkt)
   );

   ipv4rhc_fifo #(
      .Depth (QueueDepth),
      .Width ($bits(ipv4rhc_pkg::pkt_type))
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (pkt_push),
      .din   (push_pkt),
      .full  (q_full),
      .pop   (pkt_pop),
      .dout  (head_pkt),
      .empty (q_empty)
   );

   ipv4rhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pkt_avail (!q_empty),
      .pkt       (head_pkt),
      .pkt_pop   (pkt_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp_data)
   );

endmodule

FILE: design/ipv4rhc_fifo.sv
// Small flop-based queue holding finished headers between front and back.
// Generic; no package dependency.
module ipv4rhc_fifo #(
   parameter int Depth = 4,
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] dout,
   output logic             empty
);
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

FILE: design/ipv4rhc_front.sv
// Front end: takes header words, folds the checksum sum and captures fields.
// Depends on ipv4rhc_pkg.
module ipv4rhc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  ipv4rhc_pkg::req_type req,
   output logic                 pkt_push,
   output ipv4rhc_pkg::pkt_type pkt
);
   logic [4:0]  word_idx_ff, word_idx_in;
   logic [16:0] sum_ff, sum_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] ttlp_ff, ttlp_in;
   logic [15:0] csum_ff, csum_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;

   logic [4:0]  idx, nsum;
   logic [15:0] w;

   // values after this word is taken
   logic [4:0]  adv_idx;
   logic [16:0] adv_sum;
   logic [7:0]  adv_vihl;
   logic [15:0] adv_tlen, adv_ttlp, adv_csum;
   logic [31:0] adv_src, adv_dst;

   always_comb begin
      idx      = word_idx_ff;
      w        = req.header_word;
      adv_vihl = (idx == ipv4rhc_pkg::WORD_VER_IHL) ? w[15:8] : vihl_ff;
      nsum     = {adv_vihl[3:0], 1'b0};
      adv_tlen = tlen_ff;
      adv_ttlp = ttlp_ff;
      adv_csum = csum_ff;
      adv_src  = src_ff;
      adv_dst  = dst_ff;
      case (idx)
         ipv4rhc_pkg::WORD_TOTAL_LEN: adv_tlen = w;
         ipv4rhc_pkg::WORD_TTL_PROTO: adv_ttlp = w;
         ipv4rhc_pkg::WORD_CHECKSUM:  adv_csum = w;
         ipv4rhc_pkg::WORD_SRC_HI:    adv_src  = {w, src_ff[15:0]};
         ipv4rhc_pkg::WORD_SRC_LO:    adv_src  = {src_ff[31:16], w};
         ipv4rhc_pkg::WORD_DST_HI:    adv_dst  = {w, dst_ff[15:0]};
         ipv4rhc_pkg::WORD_DST_LO:    adv_dst  = {dst_ff[31:16], w};
         default: ;
      endcase
      if (idx < nsum && idx != ipv4rhc_pkg::WORD_TTL_PROTO
          && idx != ipv4rhc_pkg::WORD_CHECKSUM) begin
         adv_sum = ipv4rhc_pkg::add_carry(sum_ff, w);
      end else begin
         adv_sum = sum_ff;
      end
      adv_idx = (idx < ipv4rhc_pkg::WORD_IDX_MAX) ? idx + 5'd1 : idx;
   end

   always_comb begin
      pkt_push = accept && req.last_word;
      pkt.word_count   = adv_idx;
      pkt.sum_acc      = adv_sum;
      pkt.version_ihl  = adv_vihl;
      pkt.total_len    = adv_tlen;
      pkt.ttl_proto    = adv_ttlp;
      pkt.stored_csum  = adv_csum;
      pkt.src_addr     = adv_src;
      pkt.dst_addr     = adv_dst;
      pkt.frame_length = req.frame_length;
      pkt.adapter_id   = req.adapter_id;
   end

   always_comb begin
      word_idx_in = word_idx_ff;
      sum_in      = sum_ff;
      vihl_in     = vihl_ff;
      tlen_in     = tlen_ff;
      ttlp_in     = ttlp_ff;
      csum_in     = csum_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      if (accept) begin
         if (req.last_word) begin
            word_idx_in = '0;
            sum_in      = '0;
            vihl_in     = '0;
            tlen_in     = '0;
            ttlp_in     = '0;
            csum_in     = '0;
            src_in      = '0;
            dst_in      = '0;
         end else begin
            word_idx_in = adv_idx;
            sum_in      = adv_sum;
            vihl_in     = adv_vihl;
            tlen_in     = adv_tlen;
            ttlp_in     = adv_ttlp;
            csum_in     = adv_csum;
            src_in      = adv_src;
            dst_in      = adv_dst;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_idx_ff <= '0;
         sum_ff      <= '0;
         vihl_ff     <= '0;
         tlen_ff     <= '0;
         ttlp_ff     <= '0;
         csum_ff     <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
      end else begin
         word_idx_ff <= word_idx_in;
         sum_ff      <= sum_in;
         vihl_ff     <= vihl_in;
         tlen_ff     <= tlen_in;
         ttlp_ff     <= ttlp_in;
         csum_ff     <= csum_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
      end
   end

endmodule

FILE: design/ipv4rhc_back.sv
// Back end: checks a finished header and builds the verdict, two stages.
// Depends on ipv4rhc_pkg.
module ipv4rhc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ipv4rhc_pkg::cfg_type cfg,
   input  logic                 pkt_avail,
   input  ipv4rhc_pkg::pkt_type pkt,
   output logic                 pkt_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_pop,
   output ipv4rhc_pkg::rsp_type rsp
);
   typedef struct packed {
      logic        short_hdr;
      logic        bad_version;
      logic        bad_csum;
      logic        bad_length;
      logic        match0;
      logic        match1;
      logic        ttl_zero;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] payload_length;
      logic [7:0]  ttl;
      logic [15:0] stored_csum;
      logic [15:0] fwd_csum;
   } chk_type;

   logic    s1_valid_ff, s1_valid_in;
   chk_type s1_ff, s1_in;
   logic    out_valid_ff, out_valid_in;
   ipv4rhc_pkg::rsp_type out_ff, out_in;
   logic    out_load, s1_load;

   logic        use_ttl;
   logic [16:0] rx_sum, fwd_sum;
   logic [7:0]  ttl_dec;

   assign out_load     = !out_valid_ff || rsp_pop;
   assign s1_load      = !s1_valid_ff || out_load;
   assign pkt_pop      = s1_load && pkt_avail;
   assign s1_valid_in  = s1_load ? pkt_avail : s1_valid_ff;
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp          = out_ff;

   always_comb begin
      use_ttl = (pkt.version_ihl[3:0] >= ipv4rhc_pkg::IHL_USES_TTL);
      ttl_dec = pkt.ttl_proto[15:8] - 8'd1;
      rx_sum  = use_ttl ? ipv4rhc_pkg::add_carry(pkt.sum_acc, pkt.ttl_proto) : pkt.sum_acc;
      fwd_sum = use_ttl ? ipv4rhc_pkg::add_carry(pkt.sum_acc, {ttl_dec, pkt.ttl_proto[7:0]})
                        : pkt.sum_acc;
      s1_in.short_hdr   = (pkt.frame_length < ipv4rhc_pkg::HDR_BYTES_MIN)
                          || (pkt.word_count < ipv4rhc_pkg::HDR_WORDS_MIN);
      s1_in.bad_version = (pkt.version_ihl[7:4] != ipv4rhc_pkg::IP_VERSION);
      s1_in.bad_csum    = (~rx_sum[15:0] != pkt.stored_csum);
      s1_in.bad_length  = (pkt.total_len > pkt.frame_length);
      s1_in.match0      = ipv4rhc_pkg::iface_match(cfg.if0_addr, cfg.if0_prefix,
                             cfg.if0_adapter, cfg.if_enable[0], pkt.adapter_id, pkt.dst_addr);
      s1_in.match1      = ipv4rhc_pkg::iface_match(cfg.if1_addr, cfg.if1_prefix,
                             cfg.if1_adapter, cfg.if_enable[1], pkt.adapter_id, pkt.dst_addr);
      s1_in.ttl_zero    = (pkt.ttl_proto[15:8] == 8'd0);
      s1_in.protocol    = pkt.ttl_proto[7:0];
      s1_in.src_addr    = pkt.src_addr;
      s1_in.dst_addr    = pkt.dst_addr;
      s1_in.payload_length = (pkt.total_len >= ipv4rhc_pkg::HDR_BYTES_MIN)
                             ? pkt.total_len - ipv4rhc_pkg::HDR_BYTES_MIN : 16'd0;
      s1_in.ttl         = pkt.ttl_proto[15:8];
      s1_in.stored_csum = pkt.stored_csum;
      s1_in.fwd_csum    = ~fwd_sum[15:0];
   end

   always_comb begin
      out_in.iface_index    = 1'b0;
      out_in.protocol       = s1_ff.protocol;
      out_in.source_addr    = s1_ff.src_addr;
      out_in.dest_addr      = s1_ff.dst_addr;
      out_in.payload_length = s1_ff.payload_length;
      out_in.ttl_out        = s1_ff.ttl;
      out_in.checksum_out   = s1_ff.stored_csum;
      if (s1_ff.short_hdr) begin
         out_in.verdict = ipv4rhc_pkg::VERDICT_SHORT;
      end else if (s1_ff.bad_version) begin
         out_in.verdict = ipv4rhc_pkg::VERDICT_VERSION;
      end else if (s1_ff.bad_csum) begin
         out_in.verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
      end else if (s1_ff.bad_length) begin
         out_in.verdict = ipv4rhc_pkg::VERDICT_LENGTH;
      end else if (s1_ff.match0) begin
         out_in.verdict = ipv4rhc_pkg::VERDICT_LOCAL;
      end else if (s1_ff.match1) begin
         out_in.verdict     = ipv4rhc_pkg::VERDICT_LOCAL;
         out_in.iface_index = 1'b1;
      end else if (s1_ff.ttl_zero) begin
         out_in.verdict = ipv4rhc_pkg::VERDICT_TTL;
      end else begin
         out_in.verdict      = ipv4rhc_pkg::VERDICT_FORWARD;
         out_in.ttl_out      = s1_ff.ttl - 8'd1;
         out_in.checksum_out = s1_ff.fwd_csum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: design/ipv4rhc_checker.sv
// Port-level checker for the IPv4 receive header classifier, bound to the top level.
// Depends on ipv4rhc_pkg and the assertion macro header.
`include "ipv4_receive_header_classifier_macros.svh"

module ipv4rhc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input ipv4rhc_pkg::rsp_type rsp_data
);
   `IPV4RHC_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "result changed while waiting")
   `IPV4RHC_ASSERT_NOW(a_verdict_range, clock, reset, !rsp_empty, rsp_data.verdict <= ipv4rhc_pkg::VERDICT_TTL, "verdict code out of range")
   `IPV4RHC_ASSERT_NOW(a_iface_local, clock, reset, !rsp_empty && rsp_data.iface_index, rsp_data.verdict == ipv4rhc_pkg::VERDICT_LOCAL, "iface index set on non-local verdict")
   `IPV4RHC_ASSERT_NOW(a_fwd_ttl, clock, reset, !rsp_empty && rsp_data.verdict == ipv4rhc_pkg::VERDICT_FORWARD, rsp_data.ttl_out != 8'hFF, "forwarded ttl wrapped")
endmodule

bind ipv4_receive_header_classifier ipv4rhc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

FILE: sim/tb_ipv4_receive_header_classifier.sv
// Self-checking testbench for ipv4_receive_header_classifier: drives header words,
// predicts each verdict in a local model and checks results in order, with APB setup.
// Depends on ipv4rhc_pkg and the classifier RTL.
module tb_ipv4_receive_header_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import ipv4rhc_pkg::*;

   localparam int RX_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT    = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_WORDS   = 160;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   logic        req_full;
   req_type     req_data    = '0;
   logic        rsp_empty;
   logic        rsp_pop     = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ipv4_receive_header_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of interface registers and of the per-header capture state
   cfg_type     cfg_shadow;
   logic [4:0]  hdr_idx;
   logic [16:0] hdr_sum;
   logic [7:0]  hdr_vihl;
   logic [15:0] hdr_tlen;
   logic [15:0] hdr_ttlp;
   logic [15:0] hdr_csum;
   logic [31:0] hdr_src;
   logic [31:0] hdr_dst;

   rsp_type     expected_verdicts[$];

   int tx_idle_pct = 19;
   int rx_idle_pct = 19;
   int rx_hold_seq = 0;
   int rx_seen_seq = 0;
   int rx_hold_left = 0;
   int words_sent = 0;
   int headers_checked = 0;
   int settings_used = 0;
   int mismatches = 0;
   int unexpected_rsp = 0;
   int reg_mismatches = 0;
   int stall_cycles = 0;
   int verdict_hits [0:7];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] w);
      logic [17:0] s;
      begin
         s = {1'b0, acc} + {2'b00, w};
         s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
         s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
         return s[16:0];
      end
   endfunction

   function automatic logic [31:0] netmask(input logic [5:0] plen);
      begin
         if (plen == 6'd0) begin
            return 32'd0;
         end
         if (plen >= 6'd32) begin
            return 32'hFFFF_FFFF;
         end
         return ~(32'hFFFF_FFFF >> plen);
      end
   endfunction

   function automatic logic addr_hit(input logic [31:0] addr, input logic [5:0] plen,
                                     input logic [3:0] adapter, input logic en,
                                     input logic [3:0] rx_adapter, input logic [31:0] dst);
      logic [31:0] m;
      begin
         if (!en || adapter != rx_adapter) begin
            return 1'b0;
         end
         m = netmask(plen);
         return (dst == addr) || (((dst & m) == (addr & m)) && ((dst | m) == 32'hFFFF_FFFF));
      end
   endfunction

   function automatic void clear_header();
      begin
         hdr_idx = '0; hdr_sum = '0; hdr_vihl = '0; hdr_tlen = '0;
         hdr_ttlp = '0; hdr_csum = '0; hdr_src = '0; hdr_dst = '0;
      end
   endfunction

   function automatic void classify_word(input req_type rq, output bit emit, output rsp_type r);
      logic [4:0]  idx;
      logic [4:0]  nsum;
      logic [16:0] sum;
      logic [15:0] calc;
      logic [7:0]  ttl;
      begin
         idx = hdr_idx;
         emit = 1'b0;
         r = '0;
         if (idx == WORD_VER_IHL) begin
            hdr_vihl = rq.header_word[15:8];
         end
         nsum = {hdr_vihl[3:0], 1'b0};
         case (idx)
            WORD_TOTAL_LEN: hdr_tlen = rq.header_word;
            WORD_TTL_PROTO: hdr_ttlp = rq.header_word;
            WORD_CHECKSUM:  hdr_csum = rq.header_word;
            WORD_SRC_HI:    hdr_src[31:16] = rq.header_word;
            WORD_SRC_LO:    hdr_src[15:0] = rq.header_word;
            WORD_DST_HI:    hdr_dst[31:16] = rq.header_word;
            WORD_DST_LO:    hdr_dst[15:0] = rq.header_word;
            default: ;
         endcase
         if (idx < nsum && idx != WORD_TTL_PROTO && idx != WORD_CHECKSUM) begin
            hdr_sum = ones_add(hdr_sum, rq.header_word);
         end
         if (hdr_idx != WORD_IDX_MAX) begin
            hdr_idx = hdr_idx + 5'd1;
         end
         if (rq.last_word) begin
            emit = 1'b1;
            sum = hdr_sum;
            if (nsum > 5'd4) begin
               sum = ones_add(sum, hdr_ttlp);
            end
            calc = ~sum[15:0];
            ttl = hdr_ttlp[15:8];
            r.iface_index = 1'b0;
            r.protocol = hdr_ttlp[7:0];
            r.source_addr = hdr_src;
            r.dest_addr = hdr_dst;
            r.payload_length = (hdr_tlen >= HDR_BYTES_MIN) ? hdr_tlen - HDR_BYTES_MIN : 16'd0;
            r.ttl_out = ttl;
            r.checksum_out = hdr_csum;
            if (rq.frame_length < HDR_BYTES_MIN || hdr_idx < HDR_WORDS_MIN) begin
               r.verdict = VERDICT_SHORT;
            end else if (hdr_vihl[7:4] != IP_VERSION) begin
               r.verdict = VERDICT_VERSION;
            end else if (calc != hdr_csum) begin
               r.verdict = VERDICT_CHECKSUM;
            end else if (hdr_tlen > rq.frame_length) begin
               r.verdict = VERDICT_LENGTH;
            end else if (addr_hit(cfg_shadow.if0_addr, cfg_shadow.if0_prefix,
                                  cfg_shadow.if0_adapter, cfg_shadow.if_enable[0],
                                  rq.adapter_id, hdr_dst)) begin
               r.verdict = VERDICT_LOCAL;
            end else if (addr_hit(cfg_shadow.if1_addr, cfg_shadow.if1_prefix,
                                  cfg_shadow.if1_adapter, cfg_shadow.if_enable[1],
                                  rq.adapter_id, hdr_dst)) begin
               r.verdict = VERDICT_LOCAL;
               r.iface_index = 1'b1;
            end else if (ttl == 8'd0) begin
               r.verdict = VERDICT_TTL;
            end else begin
               r.verdict = VERDICT_FORWARD;
               r.ttl_out = ttl - 8'd1;
               sum = hdr_sum;
               if (nsum > 5'd4) begin
                  sum = ones_add(sum, {ttl - 8'd1, hdr_ttlp[7:0]});
               end
               r.checksum_out = ~sum[15:0];
            end
            clear_header();
         end
      end
   endfunction

   // request monitor, result checker and watchdog
   always @(posedge clock) begin
      bit      emit;
      rsp_type want;
      if (!reset) begin
         stall_cycles = stall_cycles + 1;
         if (req_push && !req_full) begin
            stall_cycles = 0;
            classify_word(req_data, emit, want);
            if (emit) begin
               expected_verdicts.push_back(want);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            stall_cycles = 0;
            if (expected_verdicts.size() == 0) begin
               unexpected_rsp = unexpected_rsp + 1;
               if (unexpected_rsp <= REPORT_LIMIT) begin
                  $display("unexpected result: verdict %0d dst %h", rsp_data.verdict,
                           rsp_data.dest_addr);
               end
            end else begin
               want = expected_verdicts.pop_front();
               headers_checked = headers_checked + 1;
               verdict_hits[want.verdict] = verdict_hits[want.verdict] + 1;
               if (rsp_data.verdict !== want.verdict ||
                   rsp_data.iface_index !== want.iface_index ||
                   rsp_data.protocol !== want.protocol ||
                   rsp_data.source_addr !== want.source_addr ||
                   rsp_data.dest_addr !== want.dest_addr ||
                   rsp_data.payload_length !== want.payload_length ||
                   rsp_data.ttl_out !== want.ttl_out ||
                   rsp_data.checksum_out !== want.checksum_out) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("mismatch %0d (exp/got): verdict %0d/%0d iface %0d/%0d proto %h/%h",
                              mismatches, want.verdict, rsp_data.verdict, want.iface_index,
                              rsp_data.iface_index, want.protocol, rsp_data.protocol);
                     $display("   src %h/%h dst %h/%h plen %0d/%0d ttl %0d/%0d csum %h/%h",
                              want.source_addr, rsp_data.source_addr, want.dest_addr,
                              rsp_data.dest_addr, want.payload_length, rsp_data.payload_length,
                              want.ttl_out, rsp_data.ttl_out, want.checksum_out,
                              rsp_data.checksum_out);
                  end
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("** ipv4_receive_header_classifier: FAILED **");
            $finish;
         end
      end
   end

   // receiver: random pops, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rx_hold_seq != rx_seen_seq) begin
         rx_seen_seq = rx_hold_seq;
         rx_hold_left = RX_HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left = rx_hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic push_word(input req_type item);
      begin
         while ($urandom_range(99) < tx_idle_pct) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
         req_push <= 1'b1;
         req_data <= item;
         @(posedge clock);
         while (req_full) begin
            @(posedge clock);
         end
         words_sent = words_sent + 1;
      end
   endtask

   task automatic wait_idle();
      begin
         req_push <= 1'b0;
         do begin
            @(posedge clock);
         end while (expected_verdicts.size() != 0);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {idx, 2'b00};
         csr_pwdata <= val;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) begin
            @(posedge clock);
         end
         case (idx)
            CSR_IF0_ADDR:    cfg_shadow.if0_addr = val;
            CSR_IF0_PREFIX:  cfg_shadow.if0_prefix = val[5:0];
            CSR_IF0_ADAPTER: cfg_shadow.if0_adapter = val[3:0];
            CSR_IF1_ADDR:    cfg_shadow.if1_addr = val;
            CSR_IF1_PREFIX:  cfg_shadow.if1_prefix = val[5:0];
            CSR_IF1_ADAPTER: cfg_shadow.if1_adapter = val[3:0];
            CSR_IF_ENABLE:   cfg_shadow.if_enable = val[1:0];
            default: ;
         endcase
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic verify_registers();
      logic [31:0] got;
      logic [31:0] want;
      logic [2:0]  idx;
      int          i;
      begin
         for (i = 0; i < 7; i++) begin
            idx = 3'(i);
            case (idx)
               CSR_IF0_ADDR:    want = cfg_shadow.if0_addr;
               CSR_IF0_PREFIX:  want = {26'd0, cfg_shadow.if0_prefix};
               CSR_IF0_ADAPTER: want = {28'd0, cfg_shadow.if0_adapter};
               CSR_IF1_ADDR:    want = cfg_shadow.if1_addr;
               CSR_IF1_PREFIX:  want = {26'd0, cfg_shadow.if1_prefix};
               CSR_IF1_ADAPTER: want = {28'd0, cfg_shadow.if1_adapter};
               default:         want = {30'd0, cfg_shadow.if_enable};
            endcase
            csr_psel <= 1'b1;
            csr_penable <= 1'b0;
            csr_pwrite <= 1'b0;
            csr_paddr <= {idx, 2'b00};
            @(posedge clock);
            csr_penable <= 1'b1;
            @(posedge clock);
            while (!csr_pready) begin
               @(posedge clock);
            end
            got = csr_prdata;
            csr_psel <= 1'b0;
            csr_penable <= 1'b0;
            @(posedge clock);
            if (got !== want) begin
               reg_mismatches = reg_mismatches + 1;
               if (reg_mismatches <= REPORT_LIMIT) begin
                  $display("register %0d readback: expected %h, got %h", idx, want, got);
               end
            end
         end
      end
   endtask

   task automatic program_interfaces(input cfg_type c);
      begin
         csr_write(CSR_IF0_ADDR, c.if0_addr);
         csr_write(CSR_IF0_PREFIX, {26'd0, c.if0_prefix});
         csr_write(CSR_IF0_ADAPTER, {28'd0, c.if0_adapter});
         csr_write(CSR_IF1_ADDR, c.if1_addr);
         csr_write(CSR_IF1_PREFIX, {26'd0, c.if1_prefix});
         csr_write(CSR_IF1_ADAPTER, {28'd0, c.if1_adapter});
         csr_write(CSR_IF_ENABLE, {30'd0, c.if_enable});
         settings_used = settings_used + 1;
      end
   endtask

   task automatic send_header(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [15:0] tlen, input logic [7:0] ttl,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input int nwords, input bit csum_ok,
                              input logic [15:0] flen, input logic [3:0] adp);
      logic [15:0] w [0:39];
      logic [16:0] acc;
      req_type     rq;
      int          i;
      begin
         for (i = 0; i < 40; i++) begin
            w[i] = 16'($urandom_range(16'hFFFF));
         end
         w[0] = {ver, ihl, w[0][7:0]};
         w[1] = tlen;
         w[4] = {ttl, proto};
         w[5] = 16'd0;
         w[6] = src[31:16];
         w[7] = src[15:0];
         w[8] = dst[31:16];
         w[9] = dst[15:0];
         acc = '0;
         for (i = 0; i < nwords && i < 31; i++) begin
            if (i < int'(ihl) * 2 && i != 5) begin
               acc = ones_add(acc, w[i]);
            end
         end
         w[5] = csum_ok ? ~acc[15:0] : ~acc[15:0] ^ 16'($urandom_range(1, 16'hFFFF));
         for (i = 0; i < nwords; i++) begin
            rq.header_word = w[i];
            rq.last_word = (i == nwords - 1);
            rq.frame_length = rq.last_word ? flen : 16'($urandom_range(16'hFFFF));
            rq.adapter_id = rq.last_word ? adp : 4'($urandom_range(15));
            push_word(rq);
         end
      end
   endtask

   task automatic good_header(input logic [31:0] dst, input logic [3:0] adp);
      begin
         send_header(IP_VERSION, 4'd5, 16'd40, 8'd64, 8'd17, $urandom, dst, 10, 1'b1,
                     16'd40, adp);
      end
   endtask

   task automatic random_header();
      int          kind;
      int          pick;
      int          nwords;
      bit          good;
      logic [3:0]  ver;
      logic [3:0]  ihl;
      logic [3:0]  adp;
      logic [15:0] tlen;
      logic [15:0] flen;
      logic [7:0]  ttl;
      logic [31:0] dst;
      begin
         kind = $urandom_range(99);
         ver = IP_VERSION;
         ihl = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(15));
         nwords = (int'(ihl) * 2 < 10) ? 10 : int'(ihl) * 2;
         if ($urandom_range(9) == 0) begin
            nwords = $urandom_range(10, 36);
         end
         good = 1'b1;
         tlen = 16'($urandom_range(0, 1500));
         flen = tlen + 16'($urandom_range(0, 64));
         if (kind < 5) begin
            nwords = $urandom_range(1, 9);
         end else if (kind < 8) begin
            flen = 16'($urandom_range(0, 19));
         end else if (kind < 16) begin
            ver = 4'($urandom_range(15));
            if (ver == IP_VERSION) begin
               ver = 4'd6;
            end
         end else if (kind < 24) begin
            good = 1'b0;
         end else if (kind < 30) begin
            tlen = 16'($urandom_range(16'hFFFF));
            flen = 16'($urandom_range(16'hFFFF));
         end else if (kind < 34) begin
            tlen = 16'($urandom_range(21, 16'hFFFF));
            flen = 16'($urandom_range(20, int'(tlen) - 1));
         end
         pick = $urandom_range(9);
         ttl = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd255
               : 8'($urandom_range(255));
         case ($urandom_range(5))
            0: dst = cfg_shadow.if0_addr;
            1: dst = cfg_shadow.if0_addr | ~netmask(cfg_shadow.if0_prefix);
            2: dst = cfg_shadow.if1_addr;
            3: dst = cfg_shadow.if1_addr | ~netmask(cfg_shadow.if1_prefix);
            4: dst = 32'hFFFF_FFFF;
            default: dst = $urandom;
         endcase
         pick = $urandom_range(3);
         adp = (pick == 0) ? cfg_shadow.if0_adapter : (pick == 1) ? cfg_shadow.if1_adapter
               : 4'($urandom_range(15));
         send_header(ver, ihl, tlen, ttl, 8'($urandom_range(255)), $urandom, dst, nwords,
                     good, flen, adp);
      end
   endtask

   task automatic test_register_defaults();
      begin
         verify_registers();
      end
   endtask

   task automatic test_verdict_cases();
      cfg_type c;
      begin
         c.if0_addr = 32'h0A00_0105; c.if0_prefix = 6'd24; c.if0_adapter = 4'd3;
         c.if1_addr = 32'hC0A8_0709; c.if1_prefix = 6'd16; c.if1_adapter = 4'd12;
         c.if_enable = 2'b11;
         program_interfaces(c);
         good_header(32'h0A00_0105, 4'd3);
         good_header(32'hC0A8_FFFF, 4'd12);
         good_header(32'h0808_0808, 4'd3);
         good_header(32'h0A00_0105, 4'd12);
         send_header(IP_VERSION, 4'd5, 16'd52, 8'd1, 8'd6, $urandom, 32'h0101_0101, 10, 1'b1,
                     16'd60, 4'd3);
         send_header(IP_VERSION, 4'd5, 16'd52, 8'd0, 8'd6, $urandom, 32'h0101_0101, 10, 1'b1,
                     16'd60, 4'd3);
         send_header(IP_VERSION, 4'd5, 16'd19, 8'd9, 8'd6, $urandom, 32'h0A00_0105, 10, 1'b1,
                     16'd19, 4'd3);
         send_header(IP_VERSION, 4'd5, 16'd40, 8'd9, 8'd6, $urandom, 32'h0A00_0105, 9, 1'b1,
                     16'd40, 4'd3);
         send_header(4'd6, 4'd5, 16'd40, 8'd9, 8'd6, $urandom, 32'h0A00_0105, 10, 1'b1,
                     16'd40, 4'd3);
         send_header(IP_VERSION, 4'd5, 16'd40, 8'd9, 8'd6, $urandom, 32'h0A00_0105, 10, 1'b0,
                     16'd40, 4'd3);
         send_header(IP_VERSION, 4'd5, 16'd100, 8'd9, 8'd6, $urandom, 32'h0A00_0105, 10, 1'b1,
                     16'd80, 4'd3);
         // total length under 20: payload clamps to zero
         send_header(IP_VERSION, 4'd5, 16'd0, 8'd9, 8'd6, $urandom, 32'h0202_0202, 10, 1'b1,
                     16'd20, 4'd3);
         // IHL 0 sums nothing; IHL 2 leaves TTL out of the sum
         send_header(IP_VERSION, 4'd0, 16'd40, 8'd9, 8'd6, $urandom, 32'h0202_0202, 10, 1'b1,
                     16'd40, 4'd3);
         send_header(IP_VERSION, 4'd2, 16'd40, 8'd9, 8'd6, $urandom, 32'h0202_0202, 10, 1'b1,
                     16'd40, 4'd3);
         send_header(IP_VERSION, 4'd15, 16'd60, 8'd9, 8'd6, $urandom, 32'h0202_0202, 30, 1'b1,
                     16'd60, 4'd3);
         // words past index 30 are dropped
         send_header(IP_VERSION, 4'd15, 16'd60, 8'd9, 8'd6, $urandom, 32'h0202_0202, 34, 1'b1,
                     16'd60, 4'd3);
         send_header(IP_VERSION, 4'd15, 16'hFFFF, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     10, 1'b1, 16'hFFFF, 4'd15);
         send_header(IP_VERSION, 4'd5, 16'd20, 8'd2, 8'd0, 32'd0, 32'd0, 10, 1'b1, 16'd20, 4'd0);
         wait_idle();
      end
   endtask

   task automatic test_register_extremes();
      cfg_type c;
      begin
         c.if0_addr = 32'd0; c.if0_prefix = 6'd0; c.if0_adapter = 4'd0;
         c.if1_addr = 32'hFFFF_FFFF; c.if1_prefix = 6'd32; c.if1_adapter = 4'd15;
         c.if_enable = 2'b11;
         program_interfaces(c);
         verify_registers();
         good_header(32'hFFFF_FFFF, 4'd0);
         good_header(32'hFFFF_FFFF, 4'd15);
         good_header(32'd0, 4'd0);
         random_header();
         wait_idle();

         c.if0_addr = 32'hAC10_2001; c.if0_prefix = 6'd63; c.if0_adapter = 4'd15;
         c.if1_addr = 32'h8000_0000; c.if1_prefix = 6'd1; c.if1_adapter = 4'd0;
         c.if_enable = 2'b10;
         program_interfaces(c);
         verify_registers();
         good_header(32'hFFFF_FFFF, 4'd0);
         good_header(32'hAC10_2001, 4'd15);
         random_header();
         wait_idle();

         // both interfaces claim the same address: interface 0 wins
         c.if0_addr = 32'hC0A8_0101; c.if0_prefix = 6'd24; c.if0_adapter = 4'd7;
         c.if1_addr = 32'hC0A8_0101; c.if1_prefix = 6'd24; c.if1_adapter = 4'd7;
         c.if_enable = 2'b11;
         program_interfaces(c);
         good_header(32'hC0A8_01FF, 4'd7);
         good_header(32'hC0A8_0101, 4'd7);
         random_header();
         wait_idle();

         c.if_enable = 2'b00;
         program_interfaces(c);
         verify_registers();
         good_header(32'hC0A8_0101, 4'd7);
         random_header();
         wait_idle();
      end
   endtask

   task automatic test_result_backpressure();
      int n;
      begin
         tx_idle_pct = 0;
         rx_hold_seq = rx_hold_seq + 1;
         for (n = 0; n < 8; n++) random_header();
         tx_idle_pct = 19;
         wait_idle();
      end
   endtask

   task automatic test_sender_pause();
      int n;
      begin
         for (n = 0; n < 2; n++) begin
            random_header();
            wait_idle();
         end
      end
   endtask

   task automatic test_random_traffic();
      cfg_type c;
      int      phase;
      int      start;
      begin
         for (phase = 0; phase < 4; phase++) begin
            c.if0_addr = $urandom;
            c.if0_prefix = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63))
                           : 6'($urandom_range(0, 32));
            c.if0_adapter = 4'($urandom_range(15));
            c.if1_addr = $urandom;
            c.if1_prefix = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63))
                           : 6'($urandom_range(0, 32));
            c.if1_adapter = 4'($urandom_range(15));
            c.if_enable = ($urandom_range(1) == 1) ? 2'b11 : 2'($urandom_range(3));
            program_interfaces(c);
            tx_idle_pct = (phase == 1) ? 0 : 19;
            rx_idle_pct = (phase == 1) ? 0 : 19;
            start = words_sent;
            while (words_sent - start < RANDOM_WORDS / 4) begin
               random_header();
            end
            wait_idle();
         end
         tx_idle_pct = 19;
         rx_idle_pct = 19;
      end
   endtask

   initial begin
      int n;
      for (n = 0; n < 8; n++) verdict_hits[n] = 0;
      cfg_shadow = '0;
      cfg_shadow.if0_prefix = PREFIX_RESET;
      cfg_shadow.if1_prefix = PREFIX_RESET;
      clear_header();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_verdict_cases();
      test_register_extremes();
      test_result_backpressure();
      test_sender_pause();
      test_random_traffic();
      wait_idle();

      $display("checked %0d headers from %0d words under %0d register settings",
               headers_checked, words_sent, settings_used);
      $display("local %0d, forward %0d, short %0d, version %0d, checksum %0d, length %0d, ttl %0d",
               verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
               verdict_hits[4], verdict_hits[5], verdict_hits[6]);
      if (mismatches == 0 && unexpected_rsp == 0 && reg_mismatches == 0 &&
          expected_verdicts.size() == 0) begin
         $display("** ipv4_receive_header_classifier: PASSED **");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d register errors, %0d outstanding",
                  mismatches, unexpected_rsp, reg_mismatches, expected_verdicts.size());
         $display("** ipv4_receive_header_classifier: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/ipv4rhc_pkg.sv
design/ipv4rhc_fifo.sv
design/ipv4rhc_front.sv
design/ipv4rhc_back.sv
design/ipv4_receive_header_classifier.sv
design/ipv4rhc_checker.sv
sim/tb_ipv4_receive_header_classifier.sv
